// ===== hdl/tracker_channel_effect_engine_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TRACKER_CHANNEL_EFFECT_ENGINE_DEFINES_SVH
`define TRACKER_CHANNEL_EFFECT_ENGINE_DEFINES_SVH
// Assert that an antecedent implies a consequent on the same edge.
`define TCE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert that an antecedent implies a consequent on the next edge.
`define TCE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types, constants and the vibrato sine table of the effect engine.
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int PERIOD_BITS_DEF = 20;
  localparam int PERIOD_W        = 20;
  localparam int OFFSET_W        = 13;

  localparam logic [7:0] FX_SLIDE_DOWN = 8'd0;
  localparam logic [7:0] FX_SLIDE_UP   = 8'd1;
  localparam logic [7:0] FX_GLIDE      = 8'd2;
  localparam logic [7:0] FX_FINETUNE   = 8'd3;
  localparam logic [7:0] FX_VIBRATO    = 8'd4;
  localparam logic [7:0] FX_SPEED      = 8'd5;
  localparam logic [7:0] FX_PAN        = 8'd6;
  localparam logic [7:0] FX_RETRIG     = 8'd7;
  localparam logic [7:0] FX_NONE       = 8'hFF;

  localparam logic [7:0] NOTE_EMPTY = 8'hFF;
  localparam logic [7:0] NOTE_HOLD  = 8'hFE;
  localparam logic [7:0] NOTE_REAL_LIMIT = 8'd64;

  localparam logic [1:0] GLIDE_IDLE   = 2'd0;
  localparam logic [1:0] GLIDE_ARMED  = 2'd1;
  localparam logic [1:0] GLIDE_ACTIVE = 2'd2;

  localparam int PERIOD_FLOOR = 10;

  typedef enum logic {OP_ROW = 1'b0, OP_TICK = 1'b1} op_t;

  // One channel's state record.
  typedef struct packed {
    logic [7:0]  effect;
    logic [3:0]  info;
    logic [31:0] period;
    logic signed [OFFSET_W-1:0] offset;
    logic [3:0]  glide_speed;
    logic [31:0] glide_target;
    logic [1:0]  glide_phase;
    logic [7:0]  vib_depth;
    logic [5:0]  vib_phase;
    logic [7:0]  retrig;
    logic [3:0]  fine_tune;
  } chan_state_t;

  // Registered input item.
  typedef struct packed {
    op_t         op;
    logic [2:0]  channel;
    logic [7:0]  effect_code;
    logic [3:0]  effect_info;
    logic [7:0]  note_code;
    logic [19:0] note_period;
  } item_t;

  // Result item.
  typedef struct packed {
    logic [2:0]  channel;
    logic [19:0] period;
    logic signed [OFFSET_W-1:0] offset;
    logic        restart;
    logic        trigger;
    logic [7:0]  panning;
    logic        panning_valid;
    logic [3:0]  speed;
    logic        speed_valid;
    logic [3:0]  fine_tune;
  } result_t;

  function automatic logic signed [11:0] sine(input logic [5:0] ph);
    logic [10:0] q;
    logic [3:0] i;
    i = ph[4] ? 4'(5'd16 - {1'b0, ph[3:0]}) : ph[3:0];
    case ({ph[4] & (ph[3:0] == 4'd0), i})
      5'h10: q = 11'd1024;
      5'h00: q = 11'd0;    5'h01: q = 11'd100;  5'h02: q = 11'd200;
      5'h03: q = 11'd297;  5'h04: q = 11'd392;  5'h05: q = 11'd483;
      5'h06: q = 11'd569;  5'h07: q = 11'd650;  5'h08: q = 11'd724;
      5'h09: q = 11'd792;  5'h0A: q = 11'd851;  5'h0B: q = 11'd903;
      5'h0C: q = 11'd946;  5'h0D: q = 11'd980;  5'h0E: q = 11'd1004;
      5'h0F: q = 11'd1019;
      default: q = 11'd0;
    endcase
    return ph[5] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

// ===== hdl/tce_step.sv =====
// ----------------------------------------------------------------------------
// tce_step
// Combinational row and tick update of one channel state record.
// ----------------------------------------------------------------------------
module tce_step #(
  parameter int PERIOD_BITS = tce_pkg::PERIOD_BITS_DEF
) (
  input  tce_pkg::item_t       item,
  input  tce_pkg::chan_state_t cur,
  output tce_pkg::chan_state_t nxt,
  output logic                 restart,
  output logic                 trigger,
  output logic [7:0]           panning,
  output logic                 panning_valid,
  output logic [3:0]           speed,
  output logic                 speed_valid
);
  localparam logic [33:0] PMAX = 34'((64'd1 << PERIOD_BITS) - 64'd1);

  function automatic logic [31:0] clampp(input logic signed [33:0] p,
                                         input logic signed [33:0] fl);
    logic signed [33:0] r;
    r = p;
    if (r < fl) r = fl;
    if (r > $signed(PMAX)) r = $signed(PMAX);
    return r[31:0];
  endfunction

  logic signed [33:0] p_s, t_s, step_s, np_s, folded;
  logic [31:0] np;
  logic [7:0]  fx;
  logic        trig;
  logic signed [19:0] prod;
  logic [31:0] nper_c;
  logic [7:0]  rc;

  always_comb begin
    nxt = cur;
    restart = 1'b0; trigger = 1'b0; panning = '0; panning_valid = 1'b0;
    speed = '0; speed_valid = 1'b0;
    p_s = $signed({2'b0, cur.period});
    t_s = $signed({2'b0, cur.glide_target});
    step_s = $signed({26'd0, cur.glide_speed, 4'd0});
    folded = p_s + 34'(cur.offset);
    nper_c = clampp($signed({14'd0, item.note_period}), '0);
    np = '0; np_s = '0; prod = '0; rc = '0;
    fx = cur.effect;
    trig = 1'b0;
    if (item.op == tce_pkg::OP_ROW) begin
      fx = item.effect_code;
      nxt.effect = item.effect_code;
      nxt.info = item.effect_info;
      if (fx == tce_pkg::FX_NONE) begin
        nxt.offset = '0;
      end else if (fx == tce_pkg::FX_SLIDE_DOWN || fx == tce_pkg::FX_SLIDE_UP) begin
        nxt.period = clampp(folded, '0);
        nxt.offset = '0;
        nxt.vib_phase = '0;
      end else if (fx == tce_pkg::FX_GLIDE) begin
        nxt.vib_phase = '0;
      end
      if (fx == tce_pkg::FX_SPEED && item.effect_info != 4'd0) begin
        speed = item.effect_info;
        speed_valid = 1'b1;
      end
      trig = item.note_code != tce_pkg::NOTE_EMPTY && item.note_code != tce_pkg::NOTE_HOLD;
      if (fx == tce_pkg::FX_GLIDE && trig) begin
        nxt.offset = '0;
        if (item.note_code < tce_pkg::NOTE_REAL_LIMIT) begin
          trig = 1'b0;
          nxt.glide_phase = tce_pkg::GLIDE_ARMED;
        end else begin
          nxt.glide_phase = tce_pkg::GLIDE_IDLE;
        end
      end
      if (trig) begin
        nxt.period = nper_c;
        nxt.vib_phase = '0;
        nxt.offset = '0;
        trigger = 1'b1;
      end
      case (fx)
        tce_pkg::FX_GLIDE: begin
          if (item.effect_info != 4'd0) nxt.glide_speed = item.effect_info;
          if (nxt.glide_phase == tce_pkg::GLIDE_ARMED) begin
            nxt.glide_target = nper_c;
            nxt.glide_phase = tce_pkg::GLIDE_ACTIVE;
          end
          if (nxt.glide_target != nxt.period) begin
            nxt.vib_phase = '0;
            nxt.offset = '0;
            nxt.glide_phase = tce_pkg::GLIDE_ACTIVE;
          end
        end
        tce_pkg::FX_FINETUNE: nxt.fine_tune = item.effect_info;
        tce_pkg::FX_VIBRATO: nxt.vib_depth = {item.effect_info, 4'd1};
        tce_pkg::FX_PAN: begin
          panning = 8'(item.effect_info * 8'd28);
          panning_valid = 1'b1;
        end
        tce_pkg::FX_RETRIG: if (item.effect_info != 4'd0) nxt.retrig = {4'd0, item.effect_info};
        default: ;
      endcase
    end else begin
      if (fx == tce_pkg::FX_NONE && cur.glide_phase == tce_pkg::GLIDE_ACTIVE)
        fx = tce_pkg::FX_GLIDE;
      case (fx)
        tce_pkg::FX_SLIDE_DOWN:
          nxt.period = clampp(p_s - $signed({26'd0, cur.info, 4'd0}), 34'sd10);
        tce_pkg::FX_SLIDE_UP:
          nxt.period = clampp(p_s + $signed({26'd0, cur.info, 4'd0}), 34'sd10);
        tce_pkg::FX_GLIDE: begin
          if (t_s == p_s || cur.glide_phase != tce_pkg::GLIDE_ACTIVE) begin
            nxt.glide_phase = tce_pkg::GLIDE_IDLE;
          end else if (t_s > p_s) begin
            np = clampp(p_s + step_s, 34'sd10);
            np_s = $signed({2'b0, np});
            nxt.period = (np_s > t_s) ? cur.glide_target : np;
          end else begin
            np = clampp(p_s - step_s, 34'sd10);
            np_s = $signed({2'b0, np});
            nxt.period = (np_s < t_s) ? cur.glide_target : np;
          end
        end
        tce_pkg::FX_VIBRATO: begin
          prod = 20'(tce_pkg::sine(cur.vib_phase) * $signed({1'b0, cur.vib_depth}));
          // Divide by 64 rounding toward zero.
          nxt.offset = 13'((prod + (prod[19] ? 20'sd63 : 20'sd0)) >>> 6);
          nxt.vib_phase = cur.vib_phase + 6'd1;
        end
        tce_pkg::FX_RETRIG: begin
          if (cur.info != 4'd0) begin
            rc = cur.retrig - 8'd1;
            nxt.retrig = rc;
            if (rc == 8'd0) begin
              nxt.retrig = {4'd0, cur.info};
              restart = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/tracker_channel_effect_engine.sv =====
// ----------------------------------------------------------------------------
// tracker_channel_effect_engine
// Per-channel effect engine. One item per cycle while the skid is empty: the
// item is registered, the addressed channel's state record is read from
// flip-flops, updated by one pass of combinational logic and written back,
// and the result is registered with a one-entry skid so input and output
// stall independently. A result passes from the item register to the output
// register, or to the skid while the output is held. The input stalls only
// while the skid holds a result, which happens when the output is held while
// another item waits in the item register. Because the state is written back
// at the same edge that loads the result, an item that follows directly on
// the same channel already reads the updated state. Items for a channel at or
// beyond CHANNELS leave state alone and return zeros beside the channel number.
// ----------------------------------------------------------------------------
module tracker_channel_effect_engine #(
  parameter int CHANNELS    = tce_pkg::CHANNELS_DEF,
  parameter int PERIOD_BITS = tce_pkg::PERIOD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: channel[2:0], effect_code[10:3], effect_info[14:11],
  // note_code[22:15], note_period[42:23], zero fill [47:43]
  input  logic [47:0] s_tdata,
  // tuser: operation
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: channel_out[2:0], period_out[22:3], period_offset_out[35:23],
  // restart_sample[36], note_trigger[37], panning[45:38], panning_valid[46],
  // speed[50:47], speed_valid[51], fine_tune_out[55:52]
  output logic [55:0] m_tdata
);
  tce_pkg::chan_state_t st [CHANNELS];
  tce_pkg::item_t item;
  logic item_valid;
  tce_pkg::chan_state_t cur, nxt;
  tce_pkg::result_t res;
  logic restart, trigger, pv, sv;
  logic [7:0] pan;
  logic [3:0] spd;
  logic in_range;
  logic [55:0] out_data, skid_data;
  logic out_valid, skid_valid;

  // The item register advances whenever the skid stage is empty.
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      item.op          <= tce_pkg::op_t'(s_tuser);
      item.channel     <= s_tdata[2:0];
      item.effect_code <= s_tdata[10:3];
      item.effect_info <= s_tdata[14:11];
      item.note_code   <= s_tdata[22:15];
      item.note_period <= s_tdata[42:23];
    end
  end

  assign in_range = 32'(item.channel) < CHANNELS;

  always_comb begin
    cur = st[0];
    for (int i = 0; i < CHANNELS; i++)
      if (32'(item.channel) == i) cur = st[i];
  end

  tce_step #(.PERIOD_BITS(PERIOD_BITS)) u_step (
    .item(item), .cur(cur), .nxt(nxt), .restart(restart), .trigger(trigger),
    .panning(pan), .panning_valid(pv), .speed(spd), .speed_valid(sv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++)
        st[i] <= '{effect: tce_pkg::FX_NONE, default: 0};
    end else if (item_valid && s_tready && in_range) begin
      for (int i = 0; i < CHANNELS; i++)
        if (32'(item.channel) == i) st[i] <= nxt;
    end
  end

  always_comb begin
    res = '0;
    res.channel = item.channel;
    if (in_range) begin
      res.period = nxt.period[19:0];
      res.offset = nxt.offset;
      res.restart = restart;
      res.trigger = trigger;
      res.panning = pan;
      res.panning_valid = pv;
      res.speed = spd;
      res.speed_valid = sv;
      res.fine_tune = nxt.fine_tune;
    end
  end

  // Output register with skid: a result moves into the skid if the output
  // is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        out_valid <= skid_valid || item_valid;
        skid_valid <= 1'b0;
      end else if (item_valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : 56'(res);
    end else if (!skid_valid) begin
      skid_data <= 56'(res);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {out_data[0 +: 4], out_data[4], out_data[8:5], out_data[9],
                    out_data[17:10], out_data[18], out_data[19], out_data[32:20],
                    out_data[52:33], out_data[55:53]};
endmodule

// ===== hdl/tce_checker.sv =====
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks of the effect engine.
// ----------------------------------------------------------------------------
`include "tracker_channel_effect_engine_defines.svh"
module tce_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);
  `TCE_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  `TCE_ASSERT_IMP(a_row_tick, clk, rst, m_tvalid && m_tdata[36], !m_tdata[37] && !m_tdata[46] && !m_tdata[51], "row fields on tick")
  `TCE_ASSERT_IMP(a_speed, clk, rst, m_tvalid && !m_tdata[51], m_tdata[50:47] == 4'd0, "speed without valid")
  `TCE_ASSERT_NXT(a_accept, clk, rst, s_tvalid && s_tready, ##1 m_tvalid, "accepted item gave no result")
endmodule

bind tracker_channel_effect_engine tce_checker u_tce_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the tracker channel effect engine
// Drives row and tick items through the input stream, predicts each result
// from a behavioral copy of the per-channel effect state, and compares every
// output item as a whole word in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PMAX = (1 << tce_pkg::PERIOD_W) - 1;

  // One input item as the driver sends it.
  typedef struct {
    logic        op;
    logic [47:0] data;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  tracker_channel_effect_engine u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Predicted channel state.
  logic [7:0]  ch_effect  [8];
  logic [3:0]  ch_info    [8];
  int          ch_period  [8];
  int          ch_offset  [8];
  logic [3:0]  ch_gspeed  [8];
  int          ch_gtarget [8];
  logic [1:0]  ch_gphase  [8];
  logic [7:0]  ch_vdepth  [8];
  logic [5:0]  ch_vphase  [8];
  logic [7:0]  ch_retrig  [8];
  logic [3:0]  ch_ftune   [8];

  stim_t       pending_items[$];
  logic [55:0] expected_results[$];
  int          errors = 0;
  bit          hold_sender = 0;

  function automatic int clamp_period(longint p, longint lo);
    if (p < lo) p = lo;
    if (p > PMAX) p = PMAX;
    return int'(p);
  endfunction

  // Vibrato sine sample, built from the quarter wave.
  function automatic int sine_sample(logic [5:0] ph);
    int quarter[17] = '{0, 100, 200, 297, 392, 483, 569, 650, 724, 792, 851, 903,
                        946, 980, 1004, 1019, 1024};
    int idx;
    idx = ph[4] ? 16 - ph[3:0] : ph[3:0];
    return ph[5] ? -quarter[idx] : quarter[idx];
  endfunction

  // Updates the predicted state for one item and returns the packed result.
  function automatic logic [55:0] predict_effect(logic op, logic [47:0] d);
    logic [2:0]  c;
    logic [7:0]  fx, note;
    logic [3:0]  info;
    int          nper, t, step, np;
    bit          trig;
    logic        restart, trigger, pan_v, spd_v;
    logic [7:0]  pan;
    logic [3:0]  spd;
    c = d[2:0]; fx = d[10:3]; info = d[14:11]; note = d[22:15]; nper = int'(d[42:23]);
    restart = 0; trigger = 0; pan_v = 0; spd_v = 0; pan = 0; spd = 0;
    if (op == tce_pkg::OP_ROW) begin
      ch_effect[c] = fx;
      ch_info[c] = info;
      if (fx == tce_pkg::FX_NONE) begin
        ch_offset[c] = 0;
      end else if (fx == tce_pkg::FX_SLIDE_DOWN || fx == tce_pkg::FX_SLIDE_UP) begin
        ch_period[c] = clamp_period(longint'(ch_period[c]) + ch_offset[c], 0);
        ch_offset[c] = 0;
        ch_vphase[c] = 0;
      end else if (fx == tce_pkg::FX_GLIDE) begin
        ch_vphase[c] = 0;
      end
      if (fx == tce_pkg::FX_SPEED && info != 0) begin
        spd = info; spd_v = 1;
      end
      trig = (note != tce_pkg::NOTE_EMPTY && note != tce_pkg::NOTE_HOLD);
      // A glide with a real note takes the note as target instead of triggering.
      if (fx == tce_pkg::FX_GLIDE && trig) begin
        ch_offset[c] = 0;
        if (note < tce_pkg::NOTE_REAL_LIMIT) begin
          trig = 0;
          ch_gphase[c] = tce_pkg::GLIDE_ARMED;
        end else begin
          ch_gphase[c] = tce_pkg::GLIDE_IDLE;
        end
      end
      if (trig) begin
        ch_period[c] = nper;
        ch_vphase[c] = 0;
        ch_offset[c] = 0;
        trigger = 1;
      end
      case (fx)
        tce_pkg::FX_GLIDE: begin
          if (info != 0) ch_gspeed[c] = info;
          if (ch_gphase[c] == tce_pkg::GLIDE_ARMED) begin
            ch_gtarget[c] = nper;
            ch_gphase[c] = tce_pkg::GLIDE_ACTIVE;
          end
          if (ch_gtarget[c] != ch_period[c]) begin
            ch_vphase[c] = 0;
            ch_offset[c] = 0;
            ch_gphase[c] = tce_pkg::GLIDE_ACTIVE;
          end
        end
        tce_pkg::FX_FINETUNE: ch_ftune[c] = info;
        tce_pkg::FX_VIBRATO: ch_vdepth[c] = {info, 4'd1};
        tce_pkg::FX_PAN: begin
          pan = 8'(info * 28); pan_v = 1;
        end
        tce_pkg::FX_RETRIG: if (info != 0) ch_retrig[c] = {4'd0, info};
        default: ;
      endcase
    end else begin
      fx = ch_effect[c];
      info = ch_info[c];
      if (fx == tce_pkg::FX_NONE && ch_gphase[c] == tce_pkg::GLIDE_ACTIVE)
        fx = tce_pkg::FX_GLIDE;
      case (fx)
        tce_pkg::FX_SLIDE_DOWN:
          ch_period[c] = clamp_period(longint'(ch_period[c]) - info * 16,
                                      tce_pkg::PERIOD_FLOOR);
        tce_pkg::FX_SLIDE_UP:
          ch_period[c] = clamp_period(longint'(ch_period[c]) + info * 16,
                                      tce_pkg::PERIOD_FLOOR);
        tce_pkg::FX_GLIDE: begin
          t = ch_gtarget[c];
          step = ch_gspeed[c] * 16;
          if (t == ch_period[c] || ch_gphase[c] != tce_pkg::GLIDE_ACTIVE) begin
            ch_gphase[c] = tce_pkg::GLIDE_IDLE;
          end else if (t > ch_period[c]) begin
            np = clamp_period(longint'(ch_period[c]) + step, tce_pkg::PERIOD_FLOOR);
            ch_period[c] = (np > t) ? t : np;
          end else begin
            np = clamp_period(longint'(ch_period[c]) - step, tce_pkg::PERIOD_FLOOR);
            ch_period[c] = (np < t) ? t : np;
          end
        end
        tce_pkg::FX_VIBRATO: begin
          // SystemVerilog int division truncates toward zero, as required.
          ch_offset[c] = (sine_sample(ch_vphase[c]) * int'(ch_vdepth[c])) / 64;
          ch_vphase[c] = ch_vphase[c] + 6'd1;
        end
        tce_pkg::FX_RETRIG: if (info != 0) begin
          ch_retrig[c] = ch_retrig[c] - 8'd1;
          if (ch_retrig[c] == 0) begin
            ch_retrig[c] = {4'd0, info};
            restart = 1;
          end
        end
        default: ;
      endcase
    end
    return {ch_ftune[c], spd_v, spd, pan_v, pan, trigger, restart,
            13'(ch_offset[c]), 20'(ch_period[c]), c};
  endfunction

  function automatic stim_t make_item(logic op, logic [2:0] c, logic [7:0] fx,
                                      logic [3:0] info, logic [7:0] note,
                                      logic [19:0] nper);
    stim_t s;
    s.op = op;
    s.data = {5'd0, nper, note, info, fx, c};
    return s;
  endfunction

  // Biased period: mostly mid range, sometimes at the extremes.
  function automatic logic [19:0] rand_period();
    case ($urandom_range(0, 9))
      0: return 20'(PMAX - $urandom_range(0, 40));
      1: return 20'($urandom_range(0, 40));
      2: return 20'($urandom);
      default: return 20'($urandom_range(800, 20000));
    endcase
  endfunction

  function automatic logic [7:0] rand_note();
    case ($urandom_range(0, 7))
      0: return tce_pkg::NOTE_EMPTY;
      1: return tce_pkg::NOTE_HOLD;
      2: return 8'($urandom_range(64, 253));
      default: return 8'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [7:0] rand_effect();
    case ($urandom_range(0, 11))
      0: return tce_pkg::FX_NONE;
      1: return 8'($urandom_range(8, 254));
      default: return 8'($urandom_range(0, 7));
    endcase
  endfunction

  // Driver: presents the next pending item, with random gaps between items.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_sender) begin
        stim_t s;
        s = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= s.op;
        s_tdata <= s.data;
        expected_results.push_back(predict_effect(s.op, s.data));
        send_gap <= ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 2))
                    : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, compares each accepted result in order.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, m_tdata);
          errors++;
        end else begin
          logic [55:0] exp_r;
          exp_r = expected_results.pop_front();
          if (exp_r !== m_tdata) begin
            $display("%0t: mismatch ch=%0d expected %h actual %h", $realtime,
                     exp_r[2:0], exp_r, m_tdata);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
    end
  end

  initial begin
    int n;
    logic [2:0] c;
    for (int i = 0; i < 8; i++) begin
      ch_effect[i] = tce_pkg::FX_NONE; ch_info[i] = 0; ch_period[i] = 0; ch_offset[i] = 0;
      ch_gspeed[i] = 0; ch_gtarget[i] = 0; ch_gphase[i] = tce_pkg::GLIDE_IDLE;
      ch_vdepth[i] = 0; ch_vphase[i] = 0; ch_retrig[i] = 0; ch_ftune[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: each effect, period extremes, note kinds, glide, retrig, vibrato.
    pending_items.push_back(make_item(tce_pkg::OP_TICK, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 0, tce_pkg::FX_SLIDE_UP, 15, 8'd63,
                                      20'hFFFF0));
    pending_items.push_back(make_item(tce_pkg::OP_TICK, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 1, tce_pkg::FX_SLIDE_DOWN, 15, 8'd10,
                                      20'd30));
    pending_items.push_back(make_item(tce_pkg::OP_TICK, 1, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_TICK, 1, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 2, tce_pkg::FX_NONE, 0, 8'd5, 20'd1000));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 2, tce_pkg::FX_GLIDE, 3, 8'd20,
                                      20'd1100));
    pending_items.push_back(make_item(tce_pkg::OP_TICK, 2, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 2, tce_pkg::FX_NONE, 0,
                                      tce_pkg::NOTE_EMPTY, 0));
    pending_items.push_back(make_item(tce_pkg::OP_TICK, 2, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_TICK, 2, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 3, tce_pkg::FX_GLIDE, 2, 8'd200,
                                      20'd500));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 3, tce_pkg::FX_FINETUNE, 15,
                                      tce_pkg::NOTE_HOLD, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 4, tce_pkg::FX_VIBRATO, 15, 8'd0,
                                      20'd4000));
    for (int i = 0; i < 3; i++)
      pending_items.push_back(make_item(tce_pkg::OP_TICK, 4, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 4, tce_pkg::FX_SLIDE_DOWN, 0,
                                      tce_pkg::NOTE_EMPTY, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 5, tce_pkg::FX_SPEED, 15,
                                      tce_pkg::NOTE_EMPTY, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 5, tce_pkg::FX_SPEED, 0,
                                      tce_pkg::NOTE_EMPTY, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 6, tce_pkg::FX_PAN, 15,
                                      tce_pkg::NOTE_EMPTY, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 7, tce_pkg::FX_RETRIG, 2,
                                      tce_pkg::NOTE_EMPTY, 0));
    for (int i = 0; i < 3; i++)
      pending_items.push_back(make_item(tce_pkg::OP_TICK, 7, 0, 0, 0, 0));
    pending_items.push_back(make_item(tce_pkg::OP_ROW, 7, 8'd200, 9, 8'd100, 20'hFFFFF));

    // Hold the sender until every directed result is back.
    wait (pending_items.size() == 0);
    hold_sender = 1;
    wait (expected_results.size() == 0);
    hold_sender = 0;

    // Random: a row followed by a run of ticks on one channel, with some noise.
    n = 0;
    while (n < 600) begin
      c = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(make_item(1'($urandom), 3'($urandom), 8'($urandom),
                                          4'($urandom), 8'($urandom), 20'($urandom)));
        n++;
      end else begin
        pending_items.push_back(make_item(tce_pkg::OP_ROW, c, rand_effect(), 4'($urandom),
                                          rand_note(), rand_period()));
        n++;
        repeat ($urandom_range(0, 6)) begin
          pending_items.push_back(make_item(tce_pkg::OP_TICK, c, 8'($urandom),
                                            4'($urandom), 8'($urandom), 20'($urandom)));
          n++;
        end
      end
    end

    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tce_pkg.sv
hdl/tce_step.sv
hdl/tracker_channel_effect_engine.sv
hdl/tce_checker.sv
tb/tb.sv
